FILE: sv/cbp_pkg.sv
// Shared types and constants of the character ring buffer with peek cursor.
package cbp_pkg;

    localparam int REQ_W      = 3;
    localparam int CHAR_W     = 21;
    localparam int AMOUNT_W   = 12;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W    = 11;
    localparam int SIZE_RESET = 1024;

    // Request codes on req_type
    localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESET_PEEK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SCROLL     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SEEK       = 3'd5;

    // Configuration register indexes
    localparam logic CFG_SIZE_IN_USE  = 1'b0;
    localparam logic CFG_OVERWRITE_EN = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_PEEK,
        OP_RESET_PEEK,
        OP_SCROLL,
        OP_SEEK,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [CHAR_W-1:0]           ch;
        logic signed [AMOUNT_W-1:0]  amount;
    } cmd_t;

endpackage

FILE: sv/circular_char_buffer_with_peek.sv
// Top level of the character ring buffer with read, write and peek cursors.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid / in_stall       | req_type, char_in, move_amount
//  out     | out_valid / out_stall     | char_out, char_valid, write_accepted,
//          |                           | fill_count, is_empty, peek_empty, is_full
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Read and peek make one synchronous store access, then emit from the ST_CHAR state;
// a refused read or peek, write, reset-peek and unknown requests emit from idle.
// Scroll and seek run in the step state: the cursor steps one place per cycle.
// After reset a clearing pass writes zero to all DEPTH entries;
// in_stall stays high until it ends, configuration writes are taken throughout.
// Up to two items queue between front and back, so input is taken while a result waits.
module circular_char_buffer_with_peek
#(
    parameter int DEPTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cbp_pkg::REQ_W-1:0]           req_type,
    input  logic [cbp_pkg::CHAR_W-1:0]          char_in,
    input  logic signed [cbp_pkg::AMOUNT_W-1:0] move_amount,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cbp_pkg::CHAR_W-1:0]          char_out,
    output logic                                char_valid,
    output logic                                write_accepted,
    output logic [cbp_pkg::COUNT_W-1:0]         fill_count,
    output logic                                is_empty,
    output logic                                peek_empty,
    output logic                                is_full
);

    logic          back_busy;
    logic          push_valid;
    logic          push_ready;
    cbp_pkg::cmd_t push_cmd;
    logic          q_valid;
    logic          q_pop;
    cbp_pkg::cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    cbp_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .char_in     (char_in),
        .move_amount (move_amount),
        .back_busy   (back_busy),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd)
    );

    cbp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    cbp_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_cmd          (q_cmd),
        .busy           (back_busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_out       (char_out),
        .char_valid     (char_valid),
        .write_accepted (write_accepted),
        .fill_count     (fill_count),
        .is_empty       (is_empty),
        .peek_empty     (peek_empty),
        .is_full        (is_full)
    );

endmodule

FILE: sv/cbp_front.sv
// Front end: accepts input items and classifies them into commands.
module cbp_front
(
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cbp_pkg::REQ_W-1:0]           req_type,
    input  logic [cbp_pkg::CHAR_W-1:0]          char_in,
    input  logic signed [cbp_pkg::AMOUNT_W-1:0] move_amount,
    input  logic                                back_busy,
    input  logic                                push_ready,
    output logic                                push_valid,
    output cbp_pkg::cmd_t                       push_cmd
);

    always_comb
    begin
        push_cmd.ch     = char_in;
        push_cmd.amount = move_amount;
        unique case (req_type)
            cbp_pkg::REQ_WRITE:      push_cmd.op = cbp_pkg::OP_WRITE;
            cbp_pkg::REQ_READ:       push_cmd.op = cbp_pkg::OP_READ;
            cbp_pkg::REQ_PEEK:       push_cmd.op = cbp_pkg::OP_PEEK;
            cbp_pkg::REQ_RESET_PEEK: push_cmd.op = cbp_pkg::OP_RESET_PEEK;
            cbp_pkg::REQ_SCROLL:     push_cmd.op = cbp_pkg::OP_SCROLL;
            cbp_pkg::REQ_SEEK:       push_cmd.op = cbp_pkg::OP_SEEK;
            default:                 push_cmd.op = cbp_pkg::OP_NONE;
        endcase
    end

    // hold off items while the queue is full or the store is being cleared
    assign in_stall   = !push_ready || back_busy;
    assign push_valid = in_valid && !in_stall;

endmodule

FILE: sv/cbp_queue.sv
// Two-entry command queue between the front end and the back end.
module cbp_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cbp_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output cbp_pkg::cmd_t pop_cmd
);

    cbp_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/cbp_back.sv
// Back end: ring store, cursors, counts, configuration and result register.
module cbp_back
#(
    parameter int DEPTH = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  cbp_pkg::cmd_t                        q_cmd,
    output logic                                 busy,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cbp_pkg::CHAR_W-1:0]           char_out,
    output logic                                 char_valid,
    output logic                                 write_accepted,
    output logic [cbp_pkg::COUNT_W-1:0]          fill_count,
    output logic                                 is_empty,
    output logic                                 peek_empty,
    output logic                                 is_full
);

    localparam int CW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int EW = (SW > cbp_pkg::CFG_DATA_W) ? SW : cbp_pkg::CFG_DATA_W;
    localparam int OW = cbp_pkg::COUNT_W;
    localparam int XW = cbp_pkg::CHAR_W;
    localparam int AW = cbp_pkg::AMOUNT_W;
    localparam int SIZE_INIT = (cbp_pkg::SIZE_RESET > DEPTH) ? DEPTH : cbp_pkg::SIZE_RESET;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHAR,
        ST_STEP
    } state_t;

    function automatic logic [CW-1:0] cur_inc(input logic [CW-1:0] p, input logic [SW-1:0] sz);
        logic [CW:0] s;
        s = {1'b0, p} + (CW+1)'(1);
        if (s >= (CW+1)'(sz))
        begin
            return '0;
        end
        return s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] cur_dec(input logic [CW-1:0] p, input logic [SW-1:0] sz);
        if (p == '0)
        begin
            return CW'(sz - SW'(1));
        end
        return p - CW'(1);
    endfunction

    function automatic logic [SW-1:0] cnt_inc(input logic [SW-1:0] c, input logic [SW-1:0] sz);
        logic [SW:0] s;
        s = {1'b0, c} + (SW+1)'(1);
        if (s > {1'b0, sz})
        begin
            return SW'(1);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] cnt_dec(input logic [SW-1:0] c);
        if (c == '0)
        begin
            return c;
        end
        return c - SW'(1);
    endfunction

    logic [XW-1:0] mem [DEPTH];
    logic [XW-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [CW-1:0]        clr_addr_reg, clr_addr_next;
    logic [SW-1:0]        size_reg, size_next;
    logic                 ovw_reg, ovw_next;
    logic [CW-1:0]        rd_cur_reg, rd_cur_next;
    logic [CW-1:0]        end_cur_reg, end_cur_next;
    logic [CW-1:0]        wr_cur_reg, wr_cur_next;
    logic [CW-1:0]        pk_cur_reg, pk_cur_next;
    logic [SW-1:0]        fill_reg, fill_next;
    logic [SW-1:0]        peek_reg, peek_next;
    logic signed [AW-1:0] step_reg, step_next;
    logic                 seek_reg, seek_next;

    logic                 out_valid_reg, out_valid_next;
    logic [XW-1:0]        char_out_reg, char_out_next;
    logic                 char_valid_reg, char_valid_next;
    logic                 wacc_reg, wacc_next;
    logic [OW-1:0]        fill_out_reg, fill_out_next;
    logic                 empty_reg, empty_next;
    logic                 peek_empty_reg, peek_empty_next;
    logic                 full_reg, full_next;

    logic [EW-1:0]        cfg_ext;
    logic                 slot_free;
    logic                 emit;
    logic [XW-1:0]        emit_char;
    logic                 emit_valid;
    logic                 emit_wacc;
    logic                 mem_we;
    logic [CW-1:0]        mem_wa;
    logic [XW-1:0]        mem_wd;
    logic                 mem_re;
    logic [CW-1:0]        mem_ra;

    assign cfg_ext   = EW'(cfg_data);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        size_next     = size_reg;
        ovw_next      = ovw_reg;
        rd_cur_next   = rd_cur_reg;
        end_cur_next  = end_cur_reg;
        wr_cur_next   = wr_cur_reg;
        pk_cur_next   = pk_cur_reg;
        fill_next     = fill_reg;
        peek_next     = peek_reg;
        step_next     = step_reg;
        seek_next     = seek_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        emit_char     = '0;
        emit_valid    = 1'b0;
        emit_wacc     = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = wr_cur_reg;
        mem_wd        = q_cmd.ch;
        mem_re        = 1'b0;
        mem_ra        = rd_cur_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                cbp_pkg::CFG_SIZE_IN_USE:
                begin
                    // clamp to the usable range of the store
                    if (cfg_ext == '0)
                    begin
                        size_next = SW'(1);
                    end
                    else if (cfg_ext > EW'(DEPTH))
                    begin
                        size_next = SW'(DEPTH);
                    end
                    else
                    begin
                        size_next = SW'(cfg_ext);
                    end
                end
                cbp_pkg::CFG_OVERWRITE_EN:
                begin
                    ovw_next = cfg_data[0];
                end
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                mem_wd        = '0;
                clr_addr_next = clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op) inside
                        cbp_pkg::OP_WRITE:
                        begin
                            emit = 1'b1;
                            if (!(wr_cur_reg == rd_cur_reg && fill_reg != '0 && !ovw_reg))
                            begin
                                mem_we       = 1'b1;
                                end_cur_next = cur_inc(end_cur_reg, size_reg);
                                wr_cur_next  = cur_inc(wr_cur_reg, size_reg);
                                fill_next    = cnt_inc(fill_reg, size_reg);
                                peek_next    = cnt_inc(peek_reg, size_reg);
                                emit_wacc    = 1'b1;
                            end
                        end
                        cbp_pkg::OP_READ:
                        begin
                            if (end_cur_reg == rd_cur_reg && fill_reg == '0 && !ovw_reg)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_ra      = rd_cur_reg;
                                rd_cur_next = cur_inc(rd_cur_reg, size_reg);
                                fill_next   = cnt_dec(fill_reg);
                                state_next  = ST_CHAR;
                            end
                        end
                        cbp_pkg::OP_PEEK:
                        begin
                            if (end_cur_reg == pk_cur_reg && peek_reg == '0 && !ovw_reg)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_ra      = pk_cur_reg;
                                pk_cur_next = cur_inc(pk_cur_reg, size_reg);
                                peek_next   = cnt_dec(peek_reg);
                                state_next  = ST_CHAR;
                            end
                        end
                        cbp_pkg::OP_RESET_PEEK:
                        begin
                            emit        = 1'b1;
                            pk_cur_next = rd_cur_reg;
                            peek_next   = fill_reg;
                        end
                        cbp_pkg::OP_SCROLL, cbp_pkg::OP_SEEK:
                        begin
                            step_next  = q_cmd.amount;
                            seek_next  = (q_cmd.op == cbp_pkg::OP_SEEK);
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHAR:
            begin
                emit       = 1'b1;
                emit_char  = rd_data_reg;
                emit_valid = 1'b1;
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                // advance one cursor position per cycle toward zero remaining
                if (step_reg == '0)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!step_reg[AW-1])
                begin
                    step_next = step_reg - AW'(1);
                    if (seek_reg)
                    begin
                        pk_cur_next = cur_inc(pk_cur_reg, size_reg);
                    end
                    else
                    begin
                        rd_cur_next = cur_inc(rd_cur_reg, size_reg);
                    end
                end
                else
                begin
                    step_next = step_reg + AW'(1);
                    if (seek_reg)
                    begin
                        pk_cur_next = cur_dec(pk_cur_reg, size_reg);
                    end
                    else
                    begin
                        rd_cur_next  = cur_dec(rd_cur_reg, size_reg);
                        end_cur_next = cur_dec(end_cur_reg, size_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg && out_stall;
        char_out_next   = char_out_reg;
        char_valid_next = char_valid_reg;
        wacc_next       = wacc_reg;
        fill_out_next   = fill_out_reg;
        empty_next      = empty_reg;
        peek_empty_next = peek_empty_reg;
        full_next       = full_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            char_out_next   = emit_char;
            char_valid_next = emit_valid;
            wacc_next       = emit_wacc;
            fill_out_next   = OW'(fill_next);
            empty_next      = (fill_next == '0);
            peek_empty_next = (peek_next == '0);
            full_next       = (fill_next == size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            size_reg       <= SW'(SIZE_INIT);
            ovw_reg        <= 1'b1;
            rd_cur_reg     <= '0;
            end_cur_reg    <= '0;
            wr_cur_reg     <= '0;
            pk_cur_reg     <= '0;
            fill_reg       <= '0;
            peek_reg       <= '0;
            step_reg       <= '0;
            seek_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            char_out_reg   <= '0;
            char_valid_reg <= 1'b0;
            wacc_reg       <= 1'b0;
            fill_out_reg   <= '0;
            empty_reg      <= 1'b1;
            peek_empty_reg <= 1'b1;
            full_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            size_reg       <= size_next;
            ovw_reg        <= ovw_next;
            rd_cur_reg     <= rd_cur_next;
            end_cur_reg    <= end_cur_next;
            wr_cur_reg     <= wr_cur_next;
            pk_cur_reg     <= pk_cur_next;
            fill_reg       <= fill_next;
            peek_reg       <= peek_next;
            step_reg       <= step_next;
            seek_reg       <= seek_next;
            out_valid_reg  <= out_valid_next;
            char_out_reg   <= char_out_next;
            char_valid_reg <= char_valid_next;
            wacc_reg       <= wacc_next;
            fill_out_reg   <= fill_out_next;
            empty_reg      <= empty_next;
            peek_empty_reg <= peek_empty_next;
            full_reg       <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign busy           = (state_reg == ST_CLEAR);
    assign out_valid      = out_valid_reg;
    assign char_out       = char_out_reg;
    assign char_valid     = char_valid_reg;
    assign write_accepted = wacc_reg;
    assign fill_count     = fill_out_reg;
    assign is_empty       = empty_reg;
    assign peek_empty     = peek_empty_reg;
    assign is_full        = full_reg;

`ifndef SYNTHESIS
    a_pop_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid_reg || !out_stall))
        else $error("command popped while result register is occupied");

    a_char_wait_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHAR) |-> !out_valid_reg)
        else $error("result register busy during character fetch");

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("command taken during clearing pass");

    a_size_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (size_reg != '0) && (size_reg <= SW'(DEPTH)))
        else $error("effective size out of range");
`endif

endmodule
